// ===== rtl/core/h2b64_pkg.sv =====
// Package for the hex to base64 encoder: item types, constants and the alphabet lookup.
package h2b64_pkg;

   // Input item: one hex digit character and the end-of-string flag
   typedef struct packed {
      logic [7:0] hex_char;
      logic       final_digit;
   } req_item_type;

   // Result item: one base64 character, last marker and error marker
   typedef struct packed {
      logic [7:0] out_char;
      logic       end_of_text;
      logic       bad_digit;
   } rsp_item_type;

   // One quantum of results made by a single input item
   typedef struct packed {
      logic [3:0][7:0] chars;   // character k in chars[k]
      logic            single;  // only chars[0] is sent (error result)
      logic            last;    // end of text on the final character
      logic            bad;     // error result
   } quantum_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [7:0]  PAD_CHAR    = 8'h3d;  // '='
   localparam logic [7:0]  ERR_CHAR    = 8'h00;

   // Six-bit value to its base64 alphabet character
   function automatic logic [7:0] b64_char(input logic [5:0] sext);
      logic [7:0] code;
      if (sext < 6'd26) begin
         code = 8'h41 + {2'b00, sext};
      end else if (sext < 6'd52) begin
         code = 8'h61 + {2'b00, sext} - 8'd26;
      end else if (sext < 6'd62) begin
         code = 8'h30 + {2'b00, sext} - 8'd52;
      end else if (sext == 6'd62) begin
         code = 8'h2b;
      end else begin
         code = 8'h2f;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/hex_to_base64_encoder.sv =====
// Top level of the streaming hex to base64 encoder.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   req     | in        | req_valid/req_ready | req_item  (hex_char, final_digit)
//   rsp     | out       | rsp_valid/rsp_ready | rsp_item  (out_char, end_of_text,
//           |           |                     |            bad_digit)
//
// One item is taken per cycle; state update and character lookup finish in
// the cycle the item is taken, and the results land in a two-entry queue.
// A quantum of four characters, or one for an error, leaves at one character per
// cycle while rsp_ready is high; req_ready drops only while the queue is full.
// Synchronous reset clears the digit/group state and empties the queue.
module hex_to_base64_encoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  h2b64_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output h2b64_pkg::rsp_item_type rsp_item
);

   localparam int unsigned PTR_W = $clog2(h2b64_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(h2b64_pkg::QUEUE_DEPTH + 1);

   // Encoder state
   logic [3:0]  held_nibble_ff,    held_nibble_in;
   logic        nibble_pending_ff, nibble_pending_in;
   logic [15:0] group_bytes_ff,    group_bytes_in;
   logic [1:0]  group_count_ff,    group_count_in;

   // Result queue
   h2b64_pkg::quantum_type queue_ff [h2b64_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] q_count_ff, q_count_in;
   logic [1:0]       char_idx_ff, char_idx_in;

   logic                   accept;
   logic                   push;
   logic                   pop;
   logic                   digit_ok;
   logic [3:0]             nib;
   logic [7:0]             byte_val;
   logic [23:0]            word;
   logic [2:0]             valid_chars;
   h2b64_pkg::quantum_type new_q;
   h2b64_pkg::quantum_type head_q;
   logic                   head_done;

   assign accept = req_valid && req_ready;
   assign req_ready = (q_count_ff < CNT_W'(h2b64_pkg::QUEUE_DEPTH));

   // Digit decode
   always_comb begin
      digit_ok = 1'b0;
      nib      = 4'h0;
      if (req_item.hex_char >= 8'h30 && req_item.hex_char <= 8'h39) begin
         digit_ok = 1'b1;
         nib      = req_item.hex_char[3:0];
      end else if (req_item.hex_char >= 8'h61 && req_item.hex_char <= 8'h66) begin
         digit_ok = 1'b1;
         nib      = req_item.hex_char[3:0] + 4'd9;
      end
   end

   assign byte_val = nibble_pending_ff ? {held_nibble_ff, nib} : {4'h0, nib};

   // State update and quantum build for the item on the input
   always_comb begin
      held_nibble_in    = held_nibble_ff;
      nibble_pending_in = nibble_pending_ff;
      group_bytes_in    = group_bytes_ff;
      group_count_in    = group_count_ff;
      push              = 1'b0;
      word              = 24'h0;
      valid_chars       = 3'd4;
      new_q.single      = 1'b0;
      new_q.last        = req_item.final_digit;
      new_q.bad         = 1'b0;

      if (!digit_ok) begin
         // bad digit: one error item, everything back to reset
         push              = 1'b1;
         new_q.single      = 1'b1;
         new_q.last        = 1'b1;
         new_q.bad         = 1'b1;
         held_nibble_in    = 4'h0;
         nibble_pending_in = 1'b0;
         group_bytes_in    = 16'h0;
         group_count_in    = 2'd0;
      end else if (!nibble_pending_ff && !req_item.final_digit) begin
         held_nibble_in    = nib;
         nibble_pending_in = 1'b1;
      end else begin
         held_nibble_in    = 4'h0;
         nibble_pending_in = 1'b0;
         if (group_count_ff[1]) begin
            // third byte completes the group
            push           = 1'b1;
            word           = {group_bytes_ff, byte_val};
            group_bytes_in = 16'h0;
            group_count_in = 2'd0;
         end else if (req_item.final_digit) begin
            // flush a partial group with padding
            push           = 1'b1;
            group_bytes_in = 16'h0;
            group_count_in = 2'd0;
            if (group_count_ff == 2'd0) begin
               word        = {byte_val, 16'h0};
               valid_chars = 3'd2;
            end else begin
               word        = {group_bytes_ff[7:0], byte_val, 8'h0};
               valid_chars = 3'd3;
            end
         end else begin
            group_bytes_in = {group_bytes_ff[7:0], byte_val};
            group_count_in = group_count_ff + 2'd1;
         end
      end

      for (int k = 0; k < 4; k++) begin
         if (!digit_ok) begin
            new_q.chars[k] = h2b64_pkg::ERR_CHAR;
         end else if (3'(k) < valid_chars) begin
            new_q.chars[k] = h2b64_pkg::b64_char(word[(18 - 6*k) +: 6]);
         end else begin
            new_q.chars[k] = h2b64_pkg::PAD_CHAR;
         end
      end
   end

   // Result side: serialize the head quantum
   assign head_q    = queue_ff[rd_ptr_ff];
   assign rsp_valid = (q_count_ff != '0);
   assign head_done = head_q.single || (char_idx_ff == 2'd3);
   assign pop       = rsp_valid && rsp_ready && head_done;

   always_comb begin
      rsp_item.out_char    = head_q.chars[char_idx_ff];
      rsp_item.end_of_text = head_q.last && head_done;
      rsp_item.bad_digit   = head_q.bad;
   end

   // Queue pointer and count next values
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      q_count_in  = q_count_ff;
      char_idx_in = char_idx_ff;
      if (accept && push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(h2b64_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         char_idx_in = pop ? 2'd0 : char_idx_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(h2b64_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
      end
      unique case ({accept && push, pop})
         2'b10:   q_count_in = q_count_ff + 1'b1;
         2'b01:   q_count_in = q_count_ff - 1'b1;
         default: q_count_in = q_count_ff;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_nibble_ff    <= 4'h0;
         nibble_pending_ff <= 1'b0;
         group_bytes_ff    <= 16'h0;
         group_count_ff    <= 2'd0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         q_count_ff        <= '0;
         char_idx_ff       <= 2'd0;
      end else begin
         if (accept) begin
            held_nibble_ff    <= held_nibble_in;
            nibble_pending_ff <= nibble_pending_in;
            group_bytes_ff    <= group_bytes_in;
            group_count_ff    <= group_count_in;
         end
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         q_count_ff  <= q_count_in;
         char_idx_ff <= char_idx_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (accept && push) begin
         queue_ff[wr_ptr_ff] <= new_q;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= CNT_W'(h2b64_pkg::QUEUE_DEPTH))
      else $error("result queue count above depth");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      group_count_ff != 2'd3)
      else $error("group holds more than two bytes");

   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      accept && !digit_ok |=> !nibble_pending_ff && group_count_ff == 2'd0)
      else $error("state not cleared after bad digit");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.final_digit |=> !nibble_pending_ff && group_count_ff == 2'd0)
      else $error("state not cleared after final digit");

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.bad_digit |-> rsp_item.end_of_text)
      else $error("error result not marked last");

endmodule

// ===== sim/b64_stream_checker.sv =====
// Checker for the hex to base64 encoder: predicts each result item and compares.
module b64_stream_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  h2b64_pkg::req_item_type req_item,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  h2b64_pkg::rsp_item_type rsp_item,
   output int                      error_count,
   output int                      pending_count,
   output int                      checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   // ASCII digit boundaries
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
   localparam logic [7:0] CH_LOW_F = 8'h66;  // 'f'

   // base64 alphabet, character k at bits 8*(63-k) +: 8
   localparam logic [8*64-1:0] B64_SET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // predictor state
   logic [3:0]  nib_held;
   logic        nib_waiting;
   logic [15:0] pair_bytes;
   logic [1:0]  pair_count;

   h2b64_pkg::rsp_item_type expected_chars[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   task automatic clear_encoder();
      nib_held    = 4'h0;
      nib_waiting = 1'b0;
      pair_bytes  = 16'h0000;
      pair_count  = 2'd0;
   endtask

   // queue four characters from a 24-bit word, data_chars of them real, the rest '='
   task automatic queue_quantum(input logic [23:0] word, input int data_chars,
                                input logic mark_last);
      logic [5:0]              sext;
      h2b64_pkg::rsp_item_type r;
      for (int k = 0; k < 4; k++) begin
         sext          = word[18 - 6 * k +: 6];
         r.out_char    = (k < data_chars) ? B64_SET[8 * (63 - int'(sext)) +: 8]
                                          : h2b64_pkg::PAD_CHAR;
         r.end_of_text = mark_last && (k == 3);
         r.bad_digit   = 1'b0;
         expected_chars.push_back(r);
      end
   endtask

   // advance the encoder by one digit item and queue what it produces
   task automatic encode_digit(input h2b64_pkg::req_item_type it);
      logic [3:0]              nib;
      logic [7:0]              byte_v;
      logic                    is_digit;
      h2b64_pkg::rsp_item_type r;
      is_digit = 1'b1;
      nib      = 4'h0;
      if (it.hex_char >= CH_ZERO && it.hex_char <= CH_NINE) begin
         nib = 4'(it.hex_char - CH_ZERO);
      end else if (it.hex_char >= CH_LOW_A && it.hex_char <= CH_LOW_F) begin
         nib = 4'(it.hex_char - CH_LOW_A + 8'd10);
      end else begin
         is_digit = 1'b0;
      end

      // bad digit: one error item, everything pending dropped
      if (!is_digit) begin
         clear_encoder();
         r.out_char    = h2b64_pkg::ERR_CHAR;
         r.end_of_text = 1'b1;
         r.bad_digit   = 1'b1;
         expected_chars.push_back(r);
         return;
      end

      // first nibble of a byte, or a lone final digit
      if (!nib_waiting) begin
         if (!it.final_digit) begin
            nib_held    = nib;
            nib_waiting = 1'b1;
            return;
         end
         byte_v = {4'h0, nib};
      end else begin
         byte_v      = {nib_held, nib};
         nib_waiting = 1'b0;
         nib_held    = 4'h0;
      end

      // third byte completes a group
      if (pair_count == 2'd2) begin
         queue_quantum({pair_bytes, byte_v}, 4, it.final_digit);
         clear_encoder();
         return;
      end

      pair_bytes = {pair_bytes[7:0], byte_v};
      pair_count = pair_count + 2'd1;

      // flush of a partial group, zero filled then padded
      if (it.final_digit) begin
         if (pair_count == 2'd1) begin
            queue_quantum({pair_bytes[7:0], 16'h0000}, 2, 1'b1);
         end else begin
            queue_quantum({pair_bytes, 8'h00}, 3, 1'b1);
         end
         clear_encoder();
      end
   endtask

   // results are taken before the item of the same edge, which cannot be its cause yet
   always @(posedge clock) begin
      h2b64_pkg::rsp_item_type want;
      if (reset) begin
         clear_encoder();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("checker: unexpected item char=%02h eot=%b bad=%b",
                           rsp_item.out_char, rsp_item.end_of_text, rsp_item.bad_digit);
            end else begin
               want = expected_chars.pop_front();
               checked_count++;
               if (rsp_item.out_char !== want.out_char ||
                   rsp_item.end_of_text !== want.end_of_text ||
                   rsp_item.bad_digit !== want.bad_digit) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display({"checker: item %0d expected char=%02h eot=%b bad=%b,",
                               " got char=%02h eot=%b bad=%b"},
                              checked_count, want.out_char, want.end_of_text,
                              want.bad_digit, rsp_item.out_char, rsp_item.end_of_text,
                              rsp_item.bad_digit);
               end
            end
         end
         if (req_valid && req_ready)
            encode_digit(req_item);
      end
      pending_count = expected_chars.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the hex to base64 encoder: clock, reset, stimulus, stalls and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD       = 10;
   localparam int RESET_CYCLES = 6;
   localparam int ITEM_TARGET  = 430;     // directed part plus random items, in all
   localparam int HOLD_CYCLES  = 200;     // long output stall to back up the input
   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE       = 10;

   localparam logic [8*16-1:0] HEX_SET = "0123456789abcdef";

   typedef enum int {MODE_CLEAN, MODE_BROKEN, MODE_NOISE} string_mode_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   h2b64_pkg::req_item_type req_item  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   h2b64_pkg::rsp_item_type rsp_item;

   int error_count;
   int pending_count;
   int checked_count;

   int sent_items    = 0;
   int strings_sent  = 0;
   int broken_sent   = 0;
   int cycle_count   = 0;
   bit calm          = 1'b0;  // no new random idle gaps on either side while set
   bit hold_rsp_request = 1'b0;

   hex_to_base64_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   b64_stream_checker stream_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #(PERIOD / 2) clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, pending_count);
         $display("tb: errors");
         $finish;
      end
   end

   // idle length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic [7:0] hex_digit(input int d);
      return HEX_SET[8 * (15 - d) +: 8];
   endfunction

   // offer one digit item and wait until it is taken; called and returns at a falling edge
   task automatic send_item(input logic [7:0] code, input logic last_digit);
      int gap;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{hex_char: code, final_digit: last_digit};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], i == s.len() - 1);
      strings_sent++;
   endtask

   // output side: random stalls, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0)
               stall_left = idle_len();
         end
      end
   end

   // digit stream
   initial begin
      int r;
      int len;
      int pos;
      string_mode_type mode;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone final digits, one- and two-byte flushes, group closed by the final digit
      send_text("0");
      send_text("f");
      send_text("ff");
      send_text("a9f0");
      send_text("ffffff");
      // bad digit with a nibble held
      send_item(8'h37, 1'b0);
      send_item(8'h47, 1'b0);
      // characters just outside the digit ranges, upper case, and byte extremes
      send_item(8'h2f, 1'b1);
      send_item(8'h3a, 1'b0);
      send_item(8'h60, 1'b1);
      send_item(8'h67, 1'b0);
      send_item(8'h41, 1'b1);
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b1);
      broken_sent += 8;

      // random strings: mostly well formed, some cut by a bad digit, some lone noise
      while (sent_items < ITEM_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         if (strings_sent == 20) begin
            // long hold on the output while a long string keeps coming
            calm = 1'b1;
            hold_rsp_request = 1'b1;
            len  = 24;
            mode = MODE_CLEAN;
         end else begin
            r    = $urandom_range(0, 99);
            mode = (r < 80) ? MODE_CLEAN : (r < 92) ? MODE_BROKEN : MODE_NOISE;
            r    = $urandom_range(0, 99);
            len  = (r < 70) ? $urandom_range(1, 8) :
                   (r < 95) ? $urandom_range(9, 20) : $urandom_range(21, 40);
         end
         unique case (mode)
            MODE_CLEAN: begin
               for (int i = 0; i < len; i++)
                  send_item(hex_digit($urandom_range(0, 15)), i == len - 1);
            end
            MODE_BROKEN: begin
               pos = $urandom_range(0, len - 1);
               for (int i = 0; i < pos; i++)
                  send_item(hex_digit($urandom_range(0, 15)), 1'b0);
               send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               broken_sent++;
            end
            default: begin
               send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               broken_sent++;
            end
         endcase
         strings_sent++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("summary: %0d digit items in %0d strings, %0d of them cut or noise",
               sent_items, strings_sent, broken_sent);
      $display("summary: %0d result items checked, %0d mismatches, %0d cycles",
               checked_count, error_count, cycle_count);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
